/* hw/rtl/i2cm_pkg.sv */
// Shared types and constants for the I2C master register transfer block.
// Holds the channel payload structs, the queued command struct and the
// sequencer phase codes. No dependencies.
package i2cm_pkg;

   localparam logic [7:0] READ_BIT  = 8'h01;
   localparam logic [7:0] MSB_MASK  = 8'h80;
   localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd1000;

   localparam logic [1:0] KIND_START_WR = 2'd0;
   localparam logic [1:0] KIND_START_RD = 2'd1;
   localparam logic [1:0] KIND_WR_BYTE  = 2'd2;
   localparam logic [1:0] KIND_TICK     = 2'd3;

   localparam logic [1:0] STATUS_BUSY    = 2'd0;
   localparam logic [1:0] STATUS_OK      = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [6:0]  slave_addr;
      logic        use_reg;
      logic [7:0]  sub_addr;
      logic [15:0] byte_count;
      logic [7:0]  wr_byte;
      logic        sda_sample;
   } req_type;

   typedef struct packed {
      logic        scl_level;
      logic        sda_level;
      logic [7:0]  rd_byte;
      logic        rd_valid;
      logic        want_byte;
      logic        done_res;
      logic [1:0]  status;
      logic        busy_res;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_START,
      OP_DATA,
      OP_TICK
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        read;
      logic [6:0]  slave_addr;
      logic        use_reg;
      logic [7:0]  sub_addr;
      logic [15:0] byte_count;
      logic [7:0]  wr_byte;
      logic        sda_sample;
   } cmd_type;

   typedef enum logic [4:0] {
      PH_IDLE,
      PH_ST_SDAH,
      PH_ST_SCLH,
      PH_ST_SDAL,
      PH_ST_SCLL,
      PH_TX_SDA,
      PH_TX_SCLH,
      PH_TX_SCLL,
      PH_AK_SDAH,
      PH_AK_SCLH,
      PH_AK_POLL,
      PH_WAIT_DAT,
      PH_RX_SDAH,
      PH_RX_SCLH,
      PH_RX_SCLL,
      PH_MA_SDA,
      PH_MA_SCLH,
      PH_MA_SCLL,
      PH_SP_SCLL,
      PH_SP_SDAL,
      PH_SP_SCLH,
      PH_SP_SDAH
   } phase_type;

   typedef enum logic [1:0] {
      ROLE_ADDR_W,
      ROLE_REG,
      ROLE_DATA,
      ROLE_ADDR_R
   } role_type;

endpackage

/* hw/rtl/i2cm_front.sv */
// Front end: decodes an incoming transaction into a queued command.
// Depends on i2cm_pkg.
module i2cm_front (
   input  i2cm_pkg::req_type req_payload,
   output i2cm_pkg::cmd_type cmd
);

   always_comb begin
      cmd.read       = (req_payload.kind == i2cm_pkg::KIND_START_RD);
      cmd.slave_addr = req_payload.slave_addr;
      cmd.use_reg    = req_payload.use_reg;
      cmd.sub_addr   = req_payload.sub_addr;
      cmd.byte_count = req_payload.byte_count;
      cmd.wr_byte    = req_payload.wr_byte;
      cmd.sda_sample = req_payload.sda_sample;
      case (req_payload.kind)
         i2cm_pkg::KIND_START_WR: cmd.op = i2cm_pkg::OP_START;
         i2cm_pkg::KIND_START_RD: cmd.op = i2cm_pkg::OP_START;
         i2cm_pkg::KIND_WR_BYTE:  cmd.op = i2cm_pkg::OP_DATA;
         default:                 cmd.op = i2cm_pkg::OP_TICK;
      endcase
   end

endmodule

/* hw/rtl/i2cm_queue.sv */
// Short command queue between the front end and the sequencer.
// Depends on i2cm_pkg.
module i2cm_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  i2cm_pkg::cmd_type in_cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output i2cm_pkg::cmd_type out_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   i2cm_pkg::cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign in_ready  = (count_ff != FULL_CNT);
   assign out_valid = (count_ff != '0);
   assign out_cmd   = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

/* hw/rtl/i2cm_seq.sv */
// Back end: bus sequencer, acknowledge timeout register and result register.
// Depends on i2cm_pkg.
module i2cm_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  i2cm_pkg::cmd_type cmd,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output i2cm_pkg::rsp_type rsp_payload
);

   i2cm_pkg::phase_type phase_ff, phase_in;
   i2cm_pkg::role_type  role_ff, role_in;
   logic [3:0]  bit_ff, bit_in, bit_inc;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] wait_ff, wait_in;
   logic        read_ff, read_in;
   logic [6:0]  target_ff, target_in;
   logic [7:0]  regaddr_ff, regaddr_in;
   logic        regflag_ff, regflag_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        failed_ff, failed_in;
   logic [15:0] timeout_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   i2cm_pkg::rsp_type rsp_ff, rsp_in;
   logic        fire;
   logic        ack_next_is_stop;

   assign csr_ready   = 1'b1;
   assign cmd_ready   = !rsp_valid_ff || rsp_ready;
   assign fire        = cmd_valid && cmd_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign bit_inc     = bit_ff + 4'd1;
   assign ack_next_is_stop = (left_ff == '0);

   always_comb begin
      phase_in   = phase_ff;
      role_in    = role_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      left_in    = left_ff;
      wait_in    = wait_ff;
      read_in    = read_ff;
      target_in  = target_ff;
      regaddr_in = regaddr_ff;
      regflag_in = regflag_ff;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      failed_in  = failed_ff;
      rsp_in.rd_byte  = '0;
      rsp_in.rd_valid = 1'b0;
      rsp_in.done_res = 1'b0;
      rsp_in.status   = i2cm_pkg::STATUS_BUSY;

      case (cmd.op)
         i2cm_pkg::OP_START: begin
            if (phase_ff == i2cm_pkg::PH_IDLE) begin
               read_in    = cmd.read;
               target_in  = cmd.slave_addr;
               regflag_in = cmd.use_reg;
               regaddr_in = cmd.sub_addr;
               left_in    = cmd.byte_count;
               wait_in    = '0;
               bit_in     = '0;
               failed_in  = 1'b0;
               role_in    = i2cm_pkg::ROLE_ADDR_W;
               phase_in   = i2cm_pkg::PH_ST_SDAH;
            end
         end
         i2cm_pkg::OP_DATA: begin
            if (phase_ff == i2cm_pkg::PH_WAIT_DAT) begin
               left_in  = left_ff - 16'd1;
               shift_in = cmd.wr_byte;
               bit_in   = '0;
               role_in  = i2cm_pkg::ROLE_DATA;
               phase_in = i2cm_pkg::PH_TX_SDA;
            end
         end
         default: begin
            case (phase_ff)
               i2cm_pkg::PH_ST_SDAH: begin
                  sda_in   = 1'b1;
                  phase_in = i2cm_pkg::PH_ST_SCLH;
               end
               i2cm_pkg::PH_ST_SCLH: begin
                  scl_in   = 1'b1;
                  phase_in = i2cm_pkg::PH_ST_SDAL;
               end
               i2cm_pkg::PH_ST_SDAL: begin
                  sda_in   = 1'b0;
                  phase_in = i2cm_pkg::PH_ST_SCLL;
               end
               i2cm_pkg::PH_ST_SCLL: begin
                  scl_in   = 1'b0;
                  bit_in   = '0;
                  phase_in = i2cm_pkg::PH_TX_SDA;
                  if (role_ff == i2cm_pkg::ROLE_ADDR_R) begin
                     shift_in = {target_ff, 1'b0} | i2cm_pkg::READ_BIT;
                  end else begin
                     shift_in = {target_ff, 1'b0};
                     role_in  = i2cm_pkg::ROLE_ADDR_W;
                  end
               end
               i2cm_pkg::PH_TX_SDA: begin
                  sda_in   = |(shift_ff & i2cm_pkg::MSB_MASK);
                  phase_in = i2cm_pkg::PH_TX_SCLH;
               end
               i2cm_pkg::PH_TX_SCLH: begin
                  scl_in   = 1'b1;
                  phase_in = i2cm_pkg::PH_TX_SCLL;
               end
               i2cm_pkg::PH_TX_SCLL: begin
                  scl_in   = 1'b0;
                  shift_in = {shift_ff[6:0], 1'b0};
                  if (bit_inc[3]) begin
                     bit_in   = '0;
                     phase_in = i2cm_pkg::PH_AK_SDAH;
                  end else begin
                     bit_in   = bit_inc;
                     phase_in = i2cm_pkg::PH_TX_SDA;
                  end
               end
               i2cm_pkg::PH_AK_SDAH: begin
                  sda_in   = 1'b1;
                  wait_in  = '0;
                  phase_in = i2cm_pkg::PH_AK_SCLH;
               end
               i2cm_pkg::PH_AK_SCLH: begin
                  scl_in   = 1'b1;
                  phase_in = i2cm_pkg::PH_AK_POLL;
               end
               i2cm_pkg::PH_AK_POLL: begin
                  if (!cmd.sda_sample) begin
                     scl_in = 1'b0;
                     case (role_ff)
                        i2cm_pkg::ROLE_ADDR_W, i2cm_pkg::ROLE_REG: begin
                           if (role_ff == i2cm_pkg::ROLE_ADDR_W && regflag_ff) begin
                              shift_in = regaddr_ff;
                              bit_in   = '0;
                              role_in  = i2cm_pkg::ROLE_REG;
                              phase_in = i2cm_pkg::PH_TX_SDA;
                           end else if (read_ff) begin
                              role_in  = i2cm_pkg::ROLE_ADDR_R;
                              phase_in = i2cm_pkg::PH_ST_SDAH;
                           end else begin
                              phase_in = ack_next_is_stop ? i2cm_pkg::PH_SP_SDAL
                                                          : i2cm_pkg::PH_WAIT_DAT;
                           end
                        end
                        i2cm_pkg::ROLE_DATA: begin
                           phase_in = ack_next_is_stop ? i2cm_pkg::PH_SP_SDAL
                                                       : i2cm_pkg::PH_WAIT_DAT;
                        end
                        default: begin
                           phase_in = ack_next_is_stop ? i2cm_pkg::PH_SP_SDAL
                                                       : i2cm_pkg::PH_RX_SDAH;
                        end
                     endcase
                  end else if (wait_ff >= timeout_ff) begin
                     failed_in = 1'b1;
                     phase_in  = i2cm_pkg::PH_SP_SCLL;
                  end else begin
                     wait_in = wait_ff + 16'd1;
                  end
               end
               i2cm_pkg::PH_RX_SDAH: begin
                  sda_in   = 1'b1;
                  bit_in   = '0;
                  shift_in = '0;
                  phase_in = i2cm_pkg::PH_RX_SCLH;
               end
               i2cm_pkg::PH_RX_SCLH: begin
                  scl_in   = 1'b1;
                  shift_in = {shift_ff[6:0], cmd.sda_sample};
                  phase_in = i2cm_pkg::PH_RX_SCLL;
               end
               i2cm_pkg::PH_RX_SCLL: begin
                  scl_in = 1'b0;
                  if (bit_inc[3]) begin
                     bit_in          = '0;
                     rsp_in.rd_byte  = shift_ff;
                     rsp_in.rd_valid = 1'b1;
                     left_in         = left_ff - 16'd1;
                     phase_in        = i2cm_pkg::PH_MA_SDA;
                  end else begin
                     bit_in   = bit_inc;
                     phase_in = i2cm_pkg::PH_RX_SCLH;
                  end
               end
               i2cm_pkg::PH_MA_SDA: begin
                  sda_in   = ack_next_is_stop;
                  phase_in = i2cm_pkg::PH_MA_SCLH;
               end
               i2cm_pkg::PH_MA_SCLH: begin
                  scl_in   = 1'b1;
                  phase_in = i2cm_pkg::PH_MA_SCLL;
               end
               i2cm_pkg::PH_MA_SCLL: begin
                  scl_in   = 1'b0;
                  phase_in = ack_next_is_stop ? i2cm_pkg::PH_SP_SDAL
                                              : i2cm_pkg::PH_RX_SDAH;
               end
               i2cm_pkg::PH_SP_SCLL: begin
                  scl_in   = 1'b0;
                  phase_in = i2cm_pkg::PH_SP_SDAL;
               end
               i2cm_pkg::PH_SP_SDAL: begin
                  sda_in   = 1'b0;
                  phase_in = i2cm_pkg::PH_SP_SCLH;
               end
               i2cm_pkg::PH_SP_SCLH: begin
                  scl_in   = 1'b1;
                  phase_in = i2cm_pkg::PH_SP_SDAH;
               end
               i2cm_pkg::PH_SP_SDAH: begin
                  sda_in          = 1'b1;
                  rsp_in.done_res = 1'b1;
                  rsp_in.status   = failed_ff ? i2cm_pkg::STATUS_TIMEOUT
                                              : i2cm_pkg::STATUS_OK;
                  failed_in       = 1'b0;
                  phase_in        = i2cm_pkg::PH_IDLE;
               end
               default: begin
               end
            endcase
         end
      endcase

      rsp_in.scl_level = scl_in;
      rsp_in.sda_level = sda_in;
      rsp_in.want_byte = (phase_in == i2cm_pkg::PH_WAIT_DAT);
      rsp_in.busy_res  = (phase_in != i2cm_pkg::PH_IDLE);

      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= i2cm_pkg::PH_IDLE;
         role_ff      <= i2cm_pkg::ROLE_ADDR_W;
         bit_ff       <= '0;
         shift_ff     <= '0;
         left_ff      <= '0;
         wait_ff      <= '0;
         read_ff      <= 1'b0;
         target_ff    <= '0;
         regaddr_ff   <= '0;
         regflag_ff   <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         failed_ff    <= 1'b0;
         timeout_ff   <= i2cm_pkg::ACK_TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff   <= phase_in;
            role_ff    <= role_in;
            bit_ff     <= bit_in;
            shift_ff   <= shift_in;
            left_ff    <= left_in;
            wait_ff    <= wait_in;
            read_ff    <= read_in;
            target_ff  <= target_in;
            regaddr_ff <= regaddr_in;
            regflag_ff <= regflag_in;
            scl_ff     <= scl_in;
            sda_ff     <= sda_in;
            failed_ff  <= failed_in;
         end
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   a_idle_released: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == i2cm_pkg::PH_IDLE) |-> (scl_ff && sda_ff))
      else $error("bus lines not released while idle");

   a_wait_scl_low: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == i2cm_pkg::PH_WAIT_DAT) |-> !scl_ff)
      else $error("SCL high while waiting for write data");

   a_done_status: assert property (@(posedge clock) disable iff (reset)
      (fire && rsp_in.done_res) |=>
         (rsp_ff.status == i2cm_pkg::STATUS_OK || rsp_ff.status == i2cm_pkg::STATUS_TIMEOUT))
      else $error("stop reported without final status");

   a_rd_in_read: assert property (@(posedge clock) disable iff (reset)
      (fire && rsp_in.rd_valid) |-> read_ff)
      else $error("received byte outside a read transaction");

endmodule

/* hw/rtl/i2c_master_register_transfer.sv */
// Top level of the I2C master register transfer block.
// Depends on i2cm_pkg, i2cm_front, i2cm_queue and i2cm_seq.
//
// Usage: every transaction on the req_ channel (start write, start read,
// write data byte, line tick) produces exactly one result transaction on
// the rsp_ channel, in order. The result carries the driven SCL/SDA levels,
// any received byte, the want_byte request, the stop/status report and busy.
// csr_ writes set the acknowledge timeout in ticks; the port is always
// ready; the user must write it only while the block is idle, as the
// block itself does not enforce this. An accepted request passes the
// command queue, then the sequencer result register makes its result valid.
// Throughput: one transaction per cycle while rsp_ready is high, set by the
// sequencer step that updates the bus phase and produces the result.
// When rsp_ready is low the result register holds; the queue absorbs up to
// QUEUE_DEPTH further requests before req_ready drops.
// Reset: timeout returns to 1000 ticks, both lines released, queue and
// result register empty; no clearing pass.
module i2c_master_register_transfer #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  i2cm_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output i2cm_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data
);

   i2cm_pkg::cmd_type front_cmd;
   i2cm_pkg::cmd_type head_cmd;
   logic head_valid;
   logic head_ready;

   i2cm_front u_front (
      .req_payload (req_payload),
      .cmd         (front_cmd)
   );

   i2cm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_cmd    (front_cmd),
      .out_valid (head_valid),
      .out_ready (head_ready),
      .out_cmd   (head_cmd)
   );

   i2cm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (head_valid),
      .cmd_ready   (head_ready),
      .cmd         (head_cmd),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* tb/tb_i2c_master_register_transfer.sv */
// Self-checking testbench for the I2C master register transfer block.
// Drives command, data byte and tick transactions with random gaps and stalls
// and checks every result against a scripted value or a bus sequencer model; needs i2cm_pkg.
`timescale 1ns / 100ps

module tb_i2c_master_register_transfer;

   typedef struct {
      i2cm_pkg::req_type item;
      bit                typed;
      i2cm_pkg::rsp_type want;
   } script_row_type;

   localparam int PHASE_ITEMS = 200;
   localparam int N_PHASES    = 6;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   i2cm_pkg::req_type req_payload = '0;
   logic              rsp_ready   = 1'b0;
   logic              csr_valid   = 1'b0;
   logic [15:0]       csr_data    = '0;
   logic              req_ready;
   logic              rsp_valid;
   i2cm_pkg::rsp_type rsp_payload;
   logic              csr_ready;

   // bus sequencer model state
   i2cm_pkg::phase_type bus_phase;
   i2cm_pkg::role_type  byte_role;
   logic [3:0]  bit_cnt;
   logic [7:0]  shift_byte;
   logic [15:0] bytes_todo;
   logic [15:0] poll_count;
   logic [15:0] ack_limit;
   logic        rd_mode;
   logic [6:0]  dev_latched;
   logic [7:0]  reg_latched;
   logic        reg_wanted;
   logic        scl_drv;
   logic        sda_drv;
   logic        nack_failed;

   i2cm_pkg::rsp_type line_expect[$];
   script_row_type    script[$];

   // plan of the transaction being generated
   bit          refuse;
   bit          force_refuse;
   bit          allow_refuse;
   int          refuse_after;
   int          acks_given;

   bit          steady;
   int          stall_asked;
   int          stall_served;
   int          stall_left;

   int          mismatches;
   int          rsp_checked;
   int          stops_ok;
   int          stops_nack;
   int          bytes_rx;

   i2c_master_register_transfer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #(20_000_000);
      $display("i2c_master_register_transfer verification failed");
      $finish;
   end

   function automatic i2cm_pkg::req_type mk_req(logic [1:0] kind, logic [6:0] dev,
                                                logic use_reg, logic [7:0] ra,
                                                logic [15:0] cnt, logic [7:0] wb,
                                                logic sda);
      i2cm_pkg::req_type r;
      r.kind       = kind;
      r.slave_addr = dev;
      r.use_reg    = use_reg;
      r.sub_addr   = ra;
      r.byte_count = cnt;
      r.wr_byte    = wb;
      r.sda_sample = sda;
      return r;
   endfunction

   function automatic i2cm_pkg::rsp_type lines(logic scl, logic sda, logic busy);
      i2cm_pkg::rsp_type o;
      o           = '0;
      o.scl_level = scl;
      o.sda_level = sda;
      o.busy_res  = busy;
      return o;
   endfunction

   function void load_byte(logic [7:0] b, i2cm_pkg::role_type rl);
      shift_byte = b;
      bit_cnt    = '0;
      byte_role  = rl;
      bus_phase  = i2cm_pkg::PH_TX_SDA;
   endfunction

   function void header_done();
      if (rd_mode) begin
         byte_role = i2cm_pkg::ROLE_ADDR_R;
         bus_phase = i2cm_pkg::PH_ST_SDAH;
      end else if (bytes_todo == 16'd0) begin
         bus_phase = i2cm_pkg::PH_SP_SDAL;
      end else begin
         bus_phase = i2cm_pkg::PH_WAIT_DAT;
      end
   endfunction

   function void ack_taken();
      case (byte_role)
         i2cm_pkg::ROLE_ADDR_W: begin
            if (reg_wanted) load_byte(reg_latched, i2cm_pkg::ROLE_REG);
            else header_done();
         end
         i2cm_pkg::ROLE_REG: header_done();
         i2cm_pkg::ROLE_DATA: begin
            if (bytes_todo == 16'd0) bus_phase = i2cm_pkg::PH_SP_SDAL;
            else bus_phase = i2cm_pkg::PH_WAIT_DAT;
         end
         default: begin
            if (bytes_todo == 16'd0) bus_phase = i2cm_pkg::PH_SP_SDAL;
            else bus_phase = i2cm_pkg::PH_RX_SDAH;
         end
      endcase
   endfunction

   function void bus_reset();
      ack_limit   = i2cm_pkg::ACK_TIMEOUT_RESET;
      bus_phase   = i2cm_pkg::PH_IDLE;
      byte_role   = i2cm_pkg::ROLE_ADDR_W;
      bit_cnt     = '0;
      shift_byte  = '0;
      bytes_todo  = '0;
      poll_count  = '0;
      rd_mode     = 1'b0;
      dev_latched = '0;
      reg_latched = '0;
      reg_wanted  = 1'b0;
      scl_drv     = 1'b1;
      sda_drv     = 1'b1;
      nack_failed = 1'b0;
   endfunction

   // advances the sequencer by one transaction and returns its result
   function automatic i2cm_pkg::rsp_type bus_advance(i2cm_pkg::req_type r);
      i2cm_pkg::rsp_type o;
      o = '0;
      if (r.kind == i2cm_pkg::KIND_START_WR || r.kind == i2cm_pkg::KIND_START_RD) begin
         if (bus_phase == i2cm_pkg::PH_IDLE) begin
            rd_mode     = (r.kind == i2cm_pkg::KIND_START_RD);
            dev_latched = r.slave_addr;
            reg_wanted  = r.use_reg;
            reg_latched = r.sub_addr;
            bytes_todo  = r.byte_count;
            poll_count  = '0;
            bit_cnt     = '0;
            nack_failed = 1'b0;
            byte_role   = i2cm_pkg::ROLE_ADDR_W;
            bus_phase   = i2cm_pkg::PH_ST_SDAH;
         end
      end else if (r.kind == i2cm_pkg::KIND_WR_BYTE) begin
         if (bus_phase == i2cm_pkg::PH_WAIT_DAT) begin
            bytes_todo = bytes_todo - 16'd1;
            load_byte(r.wr_byte, i2cm_pkg::ROLE_DATA);
         end
      end else begin
         case (bus_phase)
            i2cm_pkg::PH_ST_SDAH: begin
               sda_drv   = 1'b1;
               bus_phase = i2cm_pkg::PH_ST_SCLH;
            end
            i2cm_pkg::PH_ST_SCLH: begin
               scl_drv   = 1'b1;
               bus_phase = i2cm_pkg::PH_ST_SDAL;
            end
            i2cm_pkg::PH_ST_SDAL: begin
               sda_drv   = 1'b0;
               bus_phase = i2cm_pkg::PH_ST_SCLL;
            end
            i2cm_pkg::PH_ST_SCLL: begin
               scl_drv = 1'b0;
               if (byte_role == i2cm_pkg::ROLE_ADDR_R) begin
                  load_byte({dev_latched, 1'b0} | i2cm_pkg::READ_BIT, i2cm_pkg::ROLE_ADDR_R);
               end else begin
                  load_byte({dev_latched, 1'b0}, i2cm_pkg::ROLE_ADDR_W);
               end
            end
            i2cm_pkg::PH_TX_SDA: begin
               sda_drv   = (shift_byte & i2cm_pkg::MSB_MASK) != 8'h00;
               bus_phase = i2cm_pkg::PH_TX_SCLH;
            end
            i2cm_pkg::PH_TX_SCLH: begin
               scl_drv   = 1'b1;
               bus_phase = i2cm_pkg::PH_TX_SCLL;
            end
            i2cm_pkg::PH_TX_SCLL: begin
               scl_drv    = 1'b0;
               shift_byte = {shift_byte[6:0], 1'b0};
               bit_cnt    = bit_cnt + 4'd1;
               if (bit_cnt >= 4'd8) begin
                  bit_cnt   = '0;
                  bus_phase = i2cm_pkg::PH_AK_SDAH;
               end else begin
                  bus_phase = i2cm_pkg::PH_TX_SDA;
               end
            end
            i2cm_pkg::PH_AK_SDAH: begin
               sda_drv    = 1'b1;
               poll_count = '0;
               bus_phase  = i2cm_pkg::PH_AK_SCLH;
            end
            i2cm_pkg::PH_AK_SCLH: begin
               scl_drv   = 1'b1;
               bus_phase = i2cm_pkg::PH_AK_POLL;
            end
            i2cm_pkg::PH_AK_POLL: begin
               if (!r.sda_sample) begin
                  scl_drv = 1'b0;
                  ack_taken();
               end else if (poll_count >= ack_limit) begin
                  nack_failed = 1'b1;
                  bus_phase   = i2cm_pkg::PH_SP_SCLL;
               end else begin
                  poll_count = poll_count + 16'd1;
               end
            end
            i2cm_pkg::PH_RX_SDAH: begin
               sda_drv    = 1'b1;
               bit_cnt    = '0;
               shift_byte = '0;
               bus_phase  = i2cm_pkg::PH_RX_SCLH;
            end
            i2cm_pkg::PH_RX_SCLH: begin
               scl_drv    = 1'b1;
               shift_byte = {shift_byte[6:0], r.sda_sample};
               bus_phase  = i2cm_pkg::PH_RX_SCLL;
            end
            i2cm_pkg::PH_RX_SCLL: begin
               scl_drv = 1'b0;
               bit_cnt = bit_cnt + 4'd1;
               if (bit_cnt >= 4'd8) begin
                  bit_cnt    = '0;
                  o.rd_byte  = shift_byte;
                  o.rd_valid = 1'b1;
                  bytes_todo = bytes_todo - 16'd1;
                  bus_phase  = i2cm_pkg::PH_MA_SDA;
               end else begin
                  bus_phase = i2cm_pkg::PH_RX_SCLH;
               end
            end
            i2cm_pkg::PH_MA_SDA: begin
               sda_drv   = (bytes_todo == 16'd0);
               bus_phase = i2cm_pkg::PH_MA_SCLH;
            end
            i2cm_pkg::PH_MA_SCLH: begin
               scl_drv   = 1'b1;
               bus_phase = i2cm_pkg::PH_MA_SCLL;
            end
            i2cm_pkg::PH_MA_SCLL: begin
               scl_drv = 1'b0;
               if (bytes_todo == 16'd0) bus_phase = i2cm_pkg::PH_SP_SDAL;
               else bus_phase = i2cm_pkg::PH_RX_SDAH;
            end
            i2cm_pkg::PH_SP_SCLL: begin
               scl_drv   = 1'b0;
               bus_phase = i2cm_pkg::PH_SP_SDAL;
            end
            i2cm_pkg::PH_SP_SDAL: begin
               sda_drv   = 1'b0;
               bus_phase = i2cm_pkg::PH_SP_SCLH;
            end
            i2cm_pkg::PH_SP_SCLH: begin
               scl_drv   = 1'b1;
               bus_phase = i2cm_pkg::PH_SP_SDAH;
            end
            i2cm_pkg::PH_SP_SDAH: begin
               sda_drv     = 1'b1;
               o.done_res  = 1'b1;
               o.status    = nack_failed ? i2cm_pkg::STATUS_TIMEOUT : i2cm_pkg::STATUS_OK;
               nack_failed = 1'b0;
               bus_phase   = i2cm_pkg::PH_IDLE;
            end
            default: ;
         endcase
      end
      o.scl_level = scl_drv;
      o.sda_level = sda_drv;
      o.want_byte = (bus_phase == i2cm_pkg::PH_WAIT_DAT);
      o.busy_res  = (bus_phase != i2cm_pkg::PH_IDLE);
      return o;
   endfunction

   // picks the next transaction from the sequencer state; mostly well formed
   task automatic pick_item(output i2cm_pkg::req_type r, output bit real_item,
                            input bit draining);
      bit noise;
      int sz_pick;
      noise        = !draining && ($urandom_range(99) < 8);
      real_item    = !noise;
      r.slave_addr = 7'($urandom);
      r.use_reg    = 1'($urandom);
      r.sub_addr   = 8'($urandom);
      r.byte_count = 16'($urandom);
      r.wr_byte    = 8'($urandom);
      r.sda_sample = 1'($urandom);
      case (bus_phase)
         i2cm_pkg::PH_IDLE: begin
            if (noise) begin
               r.kind = $urandom_range(1) ? i2cm_pkg::KIND_WR_BYTE : i2cm_pkg::KIND_TICK;
            end else begin
               r.kind = $urandom_range(1) ? i2cm_pkg::KIND_START_RD
                                          : i2cm_pkg::KIND_START_WR;
               refuse       = force_refuse || (allow_refuse && $urandom_range(9) == 0);
               force_refuse = 1'b0;
               acks_given   = 0;
               if (refuse && $urandom_range(1)) begin
                  refuse_after = $urandom_range(1);
               end else begin
                  refuse_after = $urandom_range(3);
                  sz_pick      = $urandom_range(99);
                  if (sz_pick < 70) r.byte_count = 16'($urandom_range(2));
                  else if (sz_pick < 97) r.byte_count = 16'($urandom_range(6, 3));
                  else r.byte_count = 16'($urandom_range(12, 7));
               end
            end
         end
         i2cm_pkg::PH_WAIT_DAT: begin
            if (noise) begin
               r.kind = $urandom_range(1) ? i2cm_pkg::KIND_TICK : i2cm_pkg::KIND_START_WR;
            end else begin
               r.kind = i2cm_pkg::KIND_WR_BYTE;
            end
         end
         default: begin
            if (noise) begin
               r.kind = $urandom_range(1) ? i2cm_pkg::KIND_WR_BYTE
                                          : i2cm_pkg::KIND_START_RD;
            end else begin
               r.kind = i2cm_pkg::KIND_TICK;
               if (bus_phase == i2cm_pkg::PH_AK_POLL) begin
                  if (refuse && acks_given >= refuse_after) r.sda_sample = 1'b1;
                  else r.sda_sample = 1'($urandom_range(3) == 0);
                  if (!r.sda_sample) acks_given++;
               end
            end
         end
      endcase
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic offer(input i2cm_pkg::req_type r, input i2cm_pkg::rsp_type want);
      while (!steady && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      line_expect.push_back(want);
      @(negedge clock);
   endtask

   task automatic set_timeout(input logic [15:0] value);
      req_valid <= 1'b0;
      while (line_expect.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      ack_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   initial begin
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (stall_asked != stall_served) begin
            stall_served++;
            stall_left = 63;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 11);
         end
      end
   end

   always @(posedge clock) begin
      i2cm_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (line_expect.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result transaction, expected none, actual %0h",
                     $time, rsp_payload);
         end else begin
            want = line_expect.pop_front();
            check_field("scl_level", 32'(want.scl_level), 32'(rsp_payload.scl_level));
            check_field("sda_level", 32'(want.sda_level), 32'(rsp_payload.sda_level));
            check_field("rd_byte",   32'(want.rd_byte),   32'(rsp_payload.rd_byte));
            check_field("rd_valid",  32'(want.rd_valid),  32'(rsp_payload.rd_valid));
            check_field("want_byte", 32'(want.want_byte), 32'(rsp_payload.want_byte));
            check_field("done_res",  32'(want.done_res),  32'(rsp_payload.done_res));
            check_field("status",    32'(want.status),    32'(rsp_payload.status));
            check_field("busy_res",  32'(want.busy_res),  32'(rsp_payload.busy_res));
            rsp_checked++;
            if (want.rd_valid) bytes_rx++;
            if (want.done_res) begin
               if (want.status == i2cm_pkg::STATUS_TIMEOUT) stops_nack++;
               else stops_ok++;
            end
         end
      end
   end

   initial begin
      i2cm_pkg::req_type r;
      i2cm_pkg::rsp_type got;
      bit                real_item;
      int                counted;
      int                pending;
      logic [15:0]       phase_limit [N_PHASES];

      bus_reset();
      refuse       = 1'b0;
      force_refuse = 1'b0;
      allow_refuse = 1'b0;
      steady       = 1'b0;
      phase_limit[0] = i2cm_pkg::ACK_TIMEOUT_RESET;
      phase_limit[1] = 16'd0;
      phase_limit[2] = 16'hFFFF;
      phase_limit[3] = 16'd1;
      phase_limit[4] = 16'($urandom_range(16, 2));
      phase_limit[5] = 16'($urandom_range(2000, 17));

      // idle behavior, ignored transactions, start condition, first address bits
      script.push_back('{mk_req(i2cm_pkg::KIND_TICK, '0, 1'b0, '0, '0, '0, 1'b1), 1'b1,
                         lines(1'b1, 1'b1, 1'b0)});
      script.push_back('{mk_req(i2cm_pkg::KIND_WR_BYTE, '0, 1'b0, '0, '0, '1, 1'b0), 1'b1,
                         lines(1'b1, 1'b1, 1'b0)});
      script.push_back('{mk_req(i2cm_pkg::KIND_TICK, '0, 1'b0, '0, '0, '0, 1'b0), 1'b1,
                         lines(1'b1, 1'b1, 1'b0)});
      script.push_back('{mk_req(i2cm_pkg::KIND_START_WR, '1, 1'b1, '1, '0, '0, 1'b0), 1'b1,
                         lines(1'b1, 1'b1, 1'b1)});
      script.push_back('{mk_req(i2cm_pkg::KIND_START_RD, '0, 1'b0, '0, '1, '0, 1'b0), 1'b1,
                         lines(1'b1, 1'b1, 1'b1)});
      script.push_back('{mk_req(i2cm_pkg::KIND_START_RD, '1, 1'b1, '1, '1, '1, 1'b1), 1'b1,
                         lines(1'b1, 1'b1, 1'b1)});
      script.push_back('{mk_req(i2cm_pkg::KIND_WR_BYTE, '0, 1'b0, '0, '0, '0, 1'b0), 1'b1,
                         lines(1'b1, 1'b1, 1'b1)});
      script.push_back('{mk_req(i2cm_pkg::KIND_TICK, '0, 1'b0, '0, '0, '0, 1'b0), 1'b1,
                         lines(1'b1, 1'b1, 1'b1)});
      script.push_back('{mk_req(i2cm_pkg::KIND_TICK, '0, 1'b0, '0, '0, '0, 1'b1), 1'b1,
                         lines(1'b1, 1'b1, 1'b1)});
      script.push_back('{mk_req(i2cm_pkg::KIND_TICK, '0, 1'b0, '0, '0, '0, 1'b0), 1'b1,
                         lines(1'b1, 1'b0, 1'b1)});
      script.push_back('{mk_req(i2cm_pkg::KIND_TICK, '0, 1'b0, '0, '0, '0, 1'b1), 1'b1,
                         lines(1'b0, 1'b0, 1'b1)});
      for (int i = 0; i < 12; i++)
         script.push_back('{mk_req(i2cm_pkg::KIND_TICK, '0, 1'b0, '0, '0, '0, 1'(i)),
                            1'b0, '0});

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i]) begin
         got = bus_advance(script[i].item);
         offer(script[i].item, script[i].typed ? script[i].want : got);
      end

      for (int p = 0; p < N_PHASES; p++) begin
         if (p > 0) set_timeout(phase_limit[p]);
         steady       = (p == 4);
         force_refuse = (p == 0);
         allow_refuse = (phase_limit[p] <= 16'd16);
         counted      = 0;
         while (counted < PHASE_ITEMS || bus_phase != i2cm_pkg::PH_IDLE) begin
            pick_item(r, real_item, counted >= PHASE_ITEMS);
            got = bus_advance(r);
            offer(r, got);
            if (real_item) begin
               counted++;
               if (p == 1 && counted == 100) stall_asked++;
            end
         end
      end
      req_valid <= 1'b0;

      for (int w = 0; w < 5000 && line_expect.size() != 0; w++) @(posedge clock);
      pending = line_expect.size();
      if (pending != 0) begin
         $display("%0t: results missing, expected %0d more, actual 0", $time, pending);
      end
      repeat (8) @(posedge clock);

      $display("checked %0d results: %0d clean stops, %0d acknowledge timeouts, %0d bytes read",
               rsp_checked, stops_ok, stops_nack, bytes_rx);
      $display("ack timeout settings run: %0d %0d %0d %0d %0d %0d", phase_limit[0],
               phase_limit[1], phase_limit[2], phase_limit[3], phase_limit[4], phase_limit[5]);
      if (mismatches == 0 && pending == 0) begin
         $display("i2c_master_register_transfer verification clean");
      end else begin
         $display("i2c_master_register_transfer verification failed");
      end
      $finish;
   end

endmodule
